/* src/lsfs_pkg.sv */
// lsfs_pkg: shared types and constants of the segment lcd frame sender
// used by lsfs_front, lsfs_back and the top level; depends on nothing
`default_nettype none

package lsfs_pkg;

  // command codes on the input stream
  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_DRAW   = 3'd3;
  localparam logic [2:0] CMD_SENT   = 3'd4;

  // serial address byte that opens every frame
  localparam logic [7:0] LCD_ADDRESS = 8'h41;

  // width of the send position counter
  localparam int unsigned POS_W = 5;

  // operation after classification
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET,
    OP_CLEAR,
    OP_TOGGLE,
    OP_DRAW,
    OP_SENT
  } lsfs_op_e;

  // classified request passed from front to back
  typedef struct packed {
    lsfs_op_e   op;
    logic [4:0] seg_byte;
    logic [7:0] mask;
  } lsfs_item_t;

  // queue head seen by the back part
  typedef struct packed {
    logic       valid;
    lsfs_item_t item;
  } lsfs_head_t;

  // one result of the back part
  typedef struct packed {
    logic       frame_done;
    logic       busy_res;
    logic       chip_enable;
    logic [7:0] send_byte;
    logic       send_valid;
  } lsfs_result_t;

endpackage

`default_nettype wire

/* src/lsfs_front.sv */
// lsfs_front: accepts input requests, classifies them and queues them
// depends on lsfs_pkg
`default_nettype none

module lsfs_front #(
  parameter int unsigned FRAME_BYTES = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         command_i,
  input  wire logic [4:0]         seg_byte_i,
  input  wire logic [2:0]         seg_bit_i,
  output lsfs_pkg::lsfs_head_t    head_o,
  input  wire logic               pop_i
);

  lsfs_pkg::lsfs_item_t item_in;
  lsfs_pkg::lsfs_item_t entry_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  logic                 push;
  logic                 pop;
  logic                 in_range;

  // classify the request; out-of-range edits become no-ops
  always_comb begin
    in_range         = seg_byte_i < 5'(FRAME_BYTES);
    item_in.seg_byte = seg_byte_i;
    item_in.mask     = 8'd1 << seg_bit_i;
    case (command_i)
      lsfs_pkg::CMD_SET:    item_in.op = in_range ? lsfs_pkg::OP_SET : lsfs_pkg::OP_NOP;
      lsfs_pkg::CMD_CLEAR:  item_in.op = in_range ? lsfs_pkg::OP_CLEAR : lsfs_pkg::OP_NOP;
      lsfs_pkg::CMD_TOGGLE: item_in.op = in_range ? lsfs_pkg::OP_TOGGLE : lsfs_pkg::OP_NOP;
      lsfs_pkg::CMD_DRAW:   item_in.op = lsfs_pkg::OP_DRAW;
      lsfs_pkg::CMD_SENT:   item_in.op = lsfs_pkg::OP_SENT;
      default:              item_in.op = lsfs_pkg::OP_NOP;
    endcase
  end

  // two-entry queue control
  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

/* src/lsfs_back.sv */
// lsfs_back: executes queued requests on the segment image and frame sender
// depends on lsfs_pkg
`default_nettype none

module lsfs_back #(
  parameter int unsigned FRAME_BYTES = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lsfs_pkg::lsfs_head_t head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lsfs_pkg::lsfs_result_t   out_o
);

  localparam int unsigned IdxW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [lsfs_pkg::POS_W-1:0] FrameLen = lsfs_pkg::POS_W'(FRAME_BYTES);

  logic [7:0]                seg_img_q  [FRAME_BYTES];
  logic [7:0]                seg_img_d  [FRAME_BYTES];
  logic [7:0]                xfer_img_q [FRAME_BYTES];
  logic [lsfs_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      busy_q, busy_d;
  logic                      ce_q, ce_d;
  logic                      out_valid_q;
  lsfs_pkg::lsfs_result_t    out_q, res;
  logic                      copy;
  logic [IdxW-1:0]           edit_idx;
  logic [IdxW-1:0]           send_idx;
  logic [7:0]                cur;

  // take the next request when the result register is free or draining
  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  assign edit_idx = head_i.item.seg_byte[IdxW-1:0];
  assign send_idx = pos_q[IdxW-1:0];
  assign cur      = seg_img_q[edit_idx];

  // execute one request
  always_comb begin
    seg_img_d = seg_img_q;
    pos_d     = pos_q;
    busy_d    = busy_q;
    ce_d      = ce_q;
    copy      = 1'b0;
    res       = '0;
    case (head_i.item.op)
      lsfs_pkg::OP_SET:    seg_img_d[edit_idx] = cur | head_i.item.mask;
      lsfs_pkg::OP_CLEAR:  seg_img_d[edit_idx] = cur & ~head_i.item.mask;
      lsfs_pkg::OP_TOGGLE: seg_img_d[edit_idx] = cur ^ head_i.item.mask;
      lsfs_pkg::OP_DRAW: begin
        if (!busy_q) begin
          copy           = 1'b1;
          pos_d          = '0;
          ce_d           = 1'b0;
          busy_d         = 1'b1;
          res.send_valid = 1'b1;
          res.send_byte  = lsfs_pkg::LCD_ADDRESS;
        end
      end
      lsfs_pkg::OP_SENT: begin
        if (busy_q) begin
          if (pos_q >= FrameLen) begin
            pos_d          = '0;
            ce_d           = 1'b0;
            busy_d         = 1'b0;
            res.frame_done = 1'b1;
          end else begin
            ce_d           = 1'b1;
            res.send_valid = 1'b1;
            res.send_byte  = xfer_img_q[send_idx];
            pos_d          = pos_q + lsfs_pkg::POS_W'(1'b1);
          end
        end
      end
      default: ;
    endcase
    res.chip_enable = ce_d;
    res.busy_res    = busy_d;
  end

  // control state and segment image
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      busy_q      <= 1'b0;
      ce_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        seg_img_q[i] <= '0;
      end
    end else begin
      if (pop_o) begin
        pos_q     <= pos_d;
        busy_q    <= busy_d;
        ce_q      <= ce_d;
        seg_img_q <= seg_img_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transfer copy and result register
  always_ff @(posedge clk_i) begin
    if (pop_o && copy) begin
      xfer_img_q <= seg_img_q;
    end
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* src/lcd_segment_frame_sender_top.sv */
// lcd_segment_frame_sender_top: segment lcd frame sender, front classifier plus
// back executor; depends on lsfs_pkg, lsfs_front and lsfs_back
//
// channel  dir  handshake                    tdata / tuser
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser command, tdata seg_byte/seg_bit
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata one result per request
//
// every request gives exactly one result, one request per cycle sustained while m_axis_tready stays high
// a taken request is written into the queue and popped from there by the back part,
// which loads the result register; the result is on m_axis from then on
// a two-entry queue parts the input from the back part; m_axis stalls back up
// into the queue and then into s_axis_tready
// reset clears the segment image, the send position and all status at once
`default_nettype none

module lcd_segment_frame_sender_top #(
  parameter int unsigned FRAME_BYTES = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] seg_byte, [7:5] seg_bit
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [0] send_valid, [8:1] send_byte,
                                           // [9] chip_enable, [10] busy_res,
                                           // [11] frame_done, [15:12] zero
);

  lsfs_pkg::lsfs_head_t   head;
  lsfs_pkg::lsfs_result_t res;
  logic                   pop;

  // request classifier and queue
  lsfs_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .command_i  (s_axis_tuser),
    .seg_byte_i (s_axis_tdata[4:0]),
    .seg_bit_i  (s_axis_tdata[7:5]),
    .head_o     (head),
    .pop_i      (pop)
  );

  // image update and frame sender
  lsfs_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // pack the result, last struct field lowest
  assign m_axis_tdata = {4'b0000, res.frame_done, res.busy_res, res.chip_enable,
                         res.send_byte, res.send_valid};

endmodule

`default_nettype wire

/* src/lsfs_chk.sv */
// lsfs_chk: port-level checks of the segment lcd frame sender
// depends on lcd_segment_frame_sender_top, bound to it below
`default_nettype none

module lsfs_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a result waiting for the sink stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // nothing to send means a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'h00)
    else $error("nonzero byte without send_valid");

  // frame end drops busy and chip enable and sends nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |->
      !m_axis_tdata[10] && !m_axis_tdata[9] && !m_axis_tdata[0])
    else $error("frame done with transfer still active");

  // a send with chip enable low is the address byte of a new frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] && !m_axis_tdata[9] |->
      m_axis_tdata[8:1] == 8'h41 && m_axis_tdata[10])
    else $error("address byte mismatch");

endmodule

bind lcd_segment_frame_sender_top lsfs_chk u_lsfs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
